### design/cfe_pkg.sv
`default_nettype none

package cfe_pkg;

    localparam int unsigned WORD_WIDTH = 64;
    localparam int unsigned QDEPTH = 2;

    localparam logic [WORD_WIDTH-1:0] NEG_LIMIT = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam logic [WORD_WIDTH-1:0] POS_LIMIT = {1'b0, {(WORD_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic neg;
        logic last;
    } term_ctl_t;

    typedef struct packed {
        logic zero_den;
        logic ovf;
    } res_flags_t;

    typedef enum logic [2:0] {
        CV_IDLE,
        CV_LO,
        CV_HI,
        CV_SUM,
        CV_ACC,
        CV_FIN,
        CV_DIV,
        CV_OUT
    } conv_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_END
    } div_state_t;

endpackage

`default_nettype wire

### design/cfe_front.sv
`default_nettype none

module cfe_front #(
    parameter int unsigned TERM_WIDTH = 16
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        push,
    input  wire signed [TERM_WIDTH-1:0] term,
    input  wire                        last_term,
    output logic                       full,
    output logic                       q_valid,
    input  wire                        q_pop,
    output logic [TERM_WIDTH-1:0]      q_mag,
    output cfe_pkg::term_ctl_t         q_ctl
);
    import cfe_pkg::*;

    localparam int unsigned QAW = $clog2(QDEPTH);
    localparam int unsigned QCW = $clog2(QDEPTH + 1);

    logic [TERM_WIDTH-1:0] mag_mem [QDEPTH];
    term_ctl_t             ctl_mem [QDEPTH];
    logic [QAW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]        count_reg, count_next;
    logic                  wr_en;
    logic                  rd_en;
    logic                  term_neg;
    logic [TERM_WIDTH-1:0] term_mag;

    // split the term into sign and magnitude before it is queued
    assign term_neg = term[TERM_WIDTH-1];
    assign term_mag = term_neg ? (~term + 1'b1) : term;

    assign full    = (count_reg == QCW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign wr_en   = push && !full;
    assign rd_en   = q_pop && q_valid;
    assign q_mag   = mag_mem[rd_ptr_reg];
    assign q_ctl   = ctl_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mag_mem[wr_ptr_reg] <= term_mag;
            ctl_mem[wr_ptr_reg] <= '{neg: term_neg, last: last_term};
        end
    end

endmodule

`default_nettype wire

### design/cfe_div.sv
`default_nettype none

module cfe_div #(
    parameter int unsigned FRAC_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         start,
    input  wire  [63:0] num,
    input  wire  [63:0] den,
    output logic        done,
    output logic [63:0] value,
    output logic        ovf
);
    import cfe_pkg::*;

    localparam int unsigned DW = WORD_WIDTH + FRAC_BITS;
    localparam int unsigned CW = $clog2(DW);

    div_state_t             state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [DW-1:0]          dvd_reg;
    logic [DW-1:0]          quo_reg;
    logic [WORD_WIDTH-1:0]  rem_reg;
    logic [WORD_WIDTH-1:0]  d_reg;
    logic                   neg_reg;
    logic [WORD_WIDTH-1:0]  num_mag;
    logic [WORD_WIDTH-1:0]  den_mag;
    logic [WORD_WIDTH:0]    rem_shift;
    logic                   rem_ge;
    logic                   big;
    logic [WORD_WIDTH-1:0]  quo_low;
    logic [WORD_WIDTH-1:0]  limit;
    logic                   quo_ovf;

    assign num_mag = num[63] ? (~num + 1'b1) : num;
    assign den_mag = den[63] ? (~den + 1'b1) : den;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg, dvd_reg[DW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, d_reg});

    assign big     = |quo_reg[DW-1:WORD_WIDTH];
    assign quo_low = quo_reg[WORD_WIDTH-1:0];
    assign limit   = neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign quo_ovf = big || (quo_low > limit);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    state_next = DV_RUN;
                    cnt_next   = CW'(DW - 1);
                end
            end
            DV_RUN:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = DV_END;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            DV_END:
            begin
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done  = (state_reg == DV_END);
        ovf   = quo_ovf;
        value = quo_ovf ? limit : (neg_reg ? (~quo_low + 1'b1) : quo_low);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DV_IDLE && start)
        begin
            dvd_reg <= DW'(num_mag) << FRAC_BITS;
            d_reg   <= den_mag;
            neg_reg <= (num[63] ^ den[63]) && (num_mag != '0);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (state_reg == DV_RUN)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], 1'b0};
            quo_reg <= {quo_reg[DW-2:0], rem_ge};
            rem_reg <= rem_ge ? WORD_WIDTH'(rem_shift - {1'b0, d_reg})
                              : rem_shift[WORD_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

### design/cfe_conv.sv
`default_nettype none

module cfe_conv #(
    parameter int unsigned TERM_WIDTH = 16,
    parameter int unsigned FRAC_BITS  = 32
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        q_valid,
    output logic                       q_pop,
    input  wire  [TERM_WIDTH-1:0]      q_mag,
    input  cfe_pkg::term_ctl_t         q_ctl,
    output logic                       res_valid,
    input  wire                        res_ready,
    output logic [63:0]                res_value,
    output cfe_pkg::res_flags_t        res_flags
);
    import cfe_pkg::*;

    localparam int unsigned PW = TERM_WIDTH + 32;
    localparam int unsigned MW = TERM_WIDTH + WORD_WIDTH;

    typedef struct packed {
        logic [WORD_WIDTH-1:0] v;
        logic                  ovf;
    } madd_t;

    conv_state_t           state_reg, state_next;
    logic [WORD_WIDTH-1:0] num_cur_reg, num_prev_reg, den_cur_reg, den_prev_reg;
    logic                  sticky_reg;
    logic [TERM_WIDTH-1:0] mag_reg;
    logic                  neg_a_reg;
    logic                  last_reg;
    logic [WORD_WIDTH-1:0] mxn_reg, mxd_reg;
    logic                  sxn_reg, sxd_reg;
    logic [PW-1:0]         plon_reg, plod_reg, phin_reg, phid_reg;
    logic [WORD_WIDTH-1:0] mn_reg, md_reg;
    logic                  ov1n_reg, ov1d_reg;
    logic [WORD_WIDTH-1:0] res_value_reg;
    res_flags_t            res_flags_reg;
    logic [PW-1:0]         mul_n, mul_d;
    logic                  negn, negd;
    logic [MW-1:0]         mfull_n, mfull_d;
    logic                  ovm_n, ovm_d;
    madd_t                 acc_n, acc_d;
    logic                  den_zero;
    logic [WORD_WIDTH-1:0] sat_value;
    logic                  div_start;
    logic                  div_done;
    logic [WORD_WIDTH-1:0] div_value;
    logic                  div_ovf;

    // signed add of y and the product magnitude m, saturating
    function automatic madd_t mac_finish(input logic [WORD_WIDTH-1:0] m, input logic neg,
                                         input logic ov1, input logic [WORD_WIDTH-1:0] y);
        logic                  ps;
        logic [WORD_WIDTH-1:0] s;
        madd_t                 r;
        ps = neg && (m != '0);
        s  = neg ? (y - m) : (y + m);
        if (ov1)
        begin
            r.v   = neg ? NEG_LIMIT : POS_LIMIT;
            r.ovf = 1'b1;
        end
        else if ((ps == y[WORD_WIDTH-1]) && (s[WORD_WIDTH-1] != ps))
        begin
            r.v   = ps ? NEG_LIMIT : POS_LIMIT;
            r.ovf = 1'b1;
        end
        else
        begin
            r.v   = s;
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    assign negn = neg_a_reg ^ sxn_reg;
    assign negd = neg_a_reg ^ sxd_reg;

    // one multiplier per recurrence, low half then high half of |x|
    assign mul_n = PW'(mag_reg) * PW'((state_reg == CV_LO) ? mxn_reg[31:0] : mxn_reg[63:32]);
    assign mul_d = PW'(mag_reg) * PW'((state_reg == CV_LO) ? mxd_reg[31:0] : mxd_reg[63:32]);

    assign mfull_n = {phin_reg, 32'b0} + MW'(plon_reg);
    assign mfull_d = {phid_reg, 32'b0} + MW'(plod_reg);
    assign ovm_n   = (|mfull_n[MW-1:WORD_WIDTH]) ||
                     (mfull_n[WORD_WIDTH-1:0] > (negn ? NEG_LIMIT : POS_LIMIT));
    assign ovm_d   = (|mfull_d[MW-1:WORD_WIDTH]) ||
                     (mfull_d[WORD_WIDTH-1:0] > (negd ? NEG_LIMIT : POS_LIMIT));

    assign acc_n = mac_finish(mn_reg, negn, ov1n_reg, num_prev_reg);
    assign acc_d = mac_finish(md_reg, negd, ov1d_reg, den_prev_reg);

    assign den_zero  = (den_cur_reg == '0);
    // zero numerator counts as positive
    assign sat_value = ((num_cur_reg[63] ^ den_cur_reg[63]) && (num_cur_reg != '0))
                       ? NEG_LIMIT : POS_LIMIT;

    cfe_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (num_cur_reg),
        .den  (den_cur_reg),
        .done (div_done),
        .value(div_value),
        .ovf  (div_ovf)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CV_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = CV_LO;
                end
            end
            CV_LO:  state_next = CV_HI;
            CV_HI:  state_next = CV_SUM;
            CV_SUM: state_next = CV_ACC;
            CV_ACC: state_next = last_reg ? CV_FIN : CV_IDLE;
            CV_FIN: state_next = (den_zero || sticky_reg) ? CV_OUT : CV_DIV;
            CV_DIV:
            begin
                if (div_done)
                begin
                    state_next = CV_OUT;
                end
            end
            CV_OUT:
            begin
                if (res_ready)
                begin
                    state_next = CV_IDLE;
                end
            end
            default: state_next = CV_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == CV_IDLE) && q_valid;
        div_start = (state_reg == CV_FIN) && !den_zero && !sticky_reg;
        res_valid = (state_reg == CV_OUT);
        res_value = res_value_reg;
        res_flags = res_flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CV_IDLE;
            num_cur_reg  <= WORD_WIDTH'(1);
            num_prev_reg <= '0;
            den_cur_reg  <= '0;
            den_prev_reg <= WORD_WIDTH'(1);
            sticky_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == CV_ACC)
            begin
                num_prev_reg <= num_cur_reg;
                num_cur_reg  <= acc_n.v;
                den_prev_reg <= den_cur_reg;
                den_cur_reg  <= acc_d.v;
                sticky_reg   <= sticky_reg || acc_n.ovf || acc_d.ovf;
            end
            else if (state_reg == CV_FIN)
            begin
                // the divider has its own copy by now
                num_cur_reg  <= WORD_WIDTH'(1);
                num_prev_reg <= '0;
                den_cur_reg  <= '0;
                den_prev_reg <= WORD_WIDTH'(1);
                sticky_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CV_IDLE:
            begin
                if (q_valid)
                begin
                    mag_reg   <= q_mag;
                    neg_a_reg <= q_ctl.neg;
                    last_reg  <= q_ctl.last;
                    mxn_reg   <= num_cur_reg[63] ? (~num_cur_reg + 1'b1) : num_cur_reg;
                    mxd_reg   <= den_cur_reg[63] ? (~den_cur_reg + 1'b1) : den_cur_reg;
                    sxn_reg   <= num_cur_reg[63];
                    sxd_reg   <= den_cur_reg[63];
                end
            end
            CV_LO:
            begin
                plon_reg <= mul_n;
                plod_reg <= mul_d;
            end
            CV_HI:
            begin
                phin_reg <= mul_n;
                phid_reg <= mul_d;
            end
            CV_SUM:
            begin
                mn_reg   <= mfull_n[WORD_WIDTH-1:0];
                md_reg   <= mfull_d[WORD_WIDTH-1:0];
                ov1n_reg <= ovm_n;
                ov1d_reg <= ovm_d;
            end
            CV_FIN:
            begin
                res_value_reg <= den_zero ? '0 : sat_value;
                res_flags_reg <= '{zero_den: den_zero, ovf: sticky_reg};
            end
            CV_DIV:
            begin
                if (div_done)
                begin
                    res_value_reg <= div_value;
                    res_flags_reg <= '{zero_den: 1'b0, ovf: div_ovf};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### design/continued_fraction_evaluator_top.sv
`default_nettype none

// channel   ports                                      handshake
// terms     term, last_term                            push / full
// results   value, zero_denominator, overflowed        pop / empty
//
// each term passes through the convergent engine in steps: queue read, two half
// multiplies per recurrence on a shared pair of multipliers, magnitude sum, saturating add
// a last term adds a finish step and, unless the denominator is zero or the
// convergents overflowed, a run of the divider, which yields one quotient bit per cycle
// a two-item queue in front keeps push open while the engine works
// reset empties the queue and the output register and sets the convergents to 1/0, 0/1
// a held result stalls only the engine; the front queue keeps filling

module continued_fraction_evaluator_top #(
    parameter int unsigned TERM_WIDTH = 16,
    parameter int unsigned FRAC_BITS  = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         push,
    output logic                        full,
    input  wire signed [TERM_WIDTH-1:0] term,
    input  wire                         last_term,
    output logic                        empty,
    input  wire                         pop,
    output logic signed [63:0]          value,
    output logic                        zero_denominator,
    output logic                        overflowed
);
    import cfe_pkg::*;

    logic                  q_valid;
    logic                  q_pop;
    logic [TERM_WIDTH-1:0] q_mag;
    term_ctl_t             q_ctl;
    logic                  res_valid;
    logic                  res_ready;
    logic [63:0]           res_value;
    res_flags_t            res_flags;
    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           value_reg;
    res_flags_t            flags_reg;
    logic                  load;

    cfe_front #(
        .TERM_WIDTH(TERM_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .term     (term),
        .last_term(last_term),
        .full     (full),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_mag    (q_mag),
        .q_ctl    (q_ctl)
    );

    cfe_conv #(
        .TERM_WIDTH(TERM_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_mag    (q_mag),
        .q_ctl    (q_ctl),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_value(res_value),
        .res_flags(res_flags)
    );

    // output register refills in the cycle its item is popped
    assign res_ready = !out_valid_reg || pop;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg <= res_value;
            flags_reg <= res_flags;
        end
    end

    assign empty            = !out_valid_reg;
    assign value            = value_reg;
    assign zero_denominator = flags_reg.zero_den;
    assign overflowed       = flags_reg.ovf;

endmodule

`default_nettype wire
